[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
// Each macro is one clocked concurrent assertion, gated by the reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must hold at every rising clk edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

[hdl/sso_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the sorted set operations unit.
// No dependencies.
package sso_pkg;

    localparam int VAL_W     = 31;
    localparam int CMD_W     = 2;
    localparam int MODE_W    = 2;
    localparam int OUT_CNT_W = 7;

    localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_UNION = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INTER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIFF  = 2'd2;

    typedef logic [VAL_W-1:0] val_t;

    // per-cycle operation handed to every cell of a list chain
    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

endpackage

[hdl/sso_cell.sv]
`timescale 1ns / 1ps
// One cell of a sorted list chain: holds one element, inserts or shifts.
// Depends on sso_pkg.
module sso_cell #(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  logic              clk,
    input  sso_pkg::cell_ctrl_t ctrl,
    input  logic [CW-1:0]     cnt,
    input  sso_pkg::val_t     new_val,
    input  logic              prev_gt,
    input  sso_pkg::val_t     prev_val,
    input  sso_pkg::val_t     next_val,
    output sso_pkg::val_t     val,
    output logic              gt
);
    import sso_pkg::*;

    val_t val_reg;
    val_t val_next;

    // new value belongs at or before this cell (empty cells count as larger)
    assign gt  = (CW'(IDX) >= cnt) || (new_val < val_reg);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.insert)
        begin
            if (prev_gt)
                val_next = prev_val;
            else if (gt)
                val_next = new_val;
        end
        else if (ctrl.pop)
        begin
            val_next = next_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

[hdl/sso_chain.sv]
`timescale 1ns / 1ps
// Sorted list held as a row of cells: sorted insert on load, pop at the head.
// Depends on sso_pkg and sso_cell.
module sso_chain #(
    parameter int DEPTH = 32,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          insert,
    input  logic          pop,
    input  logic          clear,
    input  sso_pkg::val_t new_val,
    output sso_pkg::val_t head,
    output logic [CW-1:0] count,
    output logic          full
);
    import sso_pkg::*;

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    cell_ctrl_t    ctrl;
    val_t          vals [DEPTH];
    logic [DEPTH-1:0] gts;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign count = cnt_reg;
    assign head  = vals[0];
    assign ctrl.insert = insert && !full;
    assign ctrl.pop    = pop && (cnt_reg != '0);

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic prev_gt;
            val_t prev_val;
            val_t next_val;
            if (i == 0)
            begin : g_first
                assign prev_gt  = 1'b0;
                assign prev_val = new_val;
            end
            else
            begin : g_mid
                assign prev_gt  = gts[i-1];
                assign prev_val = vals[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_last
                assign next_val = vals[i];
            end
            else
            begin : g_inner
                assign next_val = vals[i+1];
            end
            sso_cell #(
                .IDX (i),
                .CW  (CW)
            ) u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .cnt      (cnt_reg),
                .new_val  (new_val),
                .prev_gt  (prev_gt),
                .prev_val (prev_val),
                .next_val (next_val),
                .val      (vals[i]),
                .gt       (gts[i])
            );
        end
    endgenerate

    always_comb
    begin
        cnt_next = cnt_reg;
        if (clear)
            cnt_next = '0;
        else if (ctrl.insert)
            cnt_next = cnt_reg + CW'(1);
        else if (ctrl.pop)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

endmodule

[hdl/sorted_set_operations_unit.sv]
`timescale 1ns / 1ps
// Sorted set operations unit: two sorted list chains and a merge sequencer.
// Depends on sso_pkg and sso_chain.
//
// Input channel (in_valid / in_stall, cmd + value): load A, load B or run.
// Loads are accepted back to back while the unit is idle; each chain keeps
// its list sorted as values arrive. A load into a full list is dropped and
// sets the sticky overflow flag, shown on load_overflow with the result beats.
// A run raises in_stall until its last result beat has been handed to the
// output register. The merge pops one head (or both) per cycle while the
// output register can take a beat, and waits while the receiver stalls.
// Results lag the merge by one element so the final beat can carry out_last
// and out_count; an empty result gives one beat with out_empty set. The run
// then clears both lists and the overflow flag.
// Output channel (out_valid / out_stall): a registered beat holds steady
// while out_stall is high and the merge waits for it.
// Config channel (cfg_valid / cfg_ready, cfg_data = set_mode) is always
// ready; the user must write it only while the unit is idle, as the block does not enforce it.
// Reset (rst_n low) empties both lists, clears the flag and sets union mode.
module sorted_set_operations_unit #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [sso_pkg::CMD_W-1:0]     cmd,
    input  logic [sso_pkg::VAL_W-1:0]     value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sso_pkg::VAL_W-1:0]     out_value,
    output logic                          out_last,
    output logic [sso_pkg::OUT_CNT_W-1:0] out_count,
    output logic                          out_empty,
    output logic                          load_overflow,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sso_pkg::MODE_W-1:0]    cfg_data
);
    import sso_pkg::*;

    localparam int CW = $clog2(LIST_DEPTH + 1);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_MERGE = 1'b1;

    logic                 state_reg, state_next;
    logic [MODE_W-1:0]    mode_reg;
    logic                 ovf_reg, ovf_next;
    logic [OUT_CNT_W-1:0] k_reg, k_next;
    val_t                 pend_reg, pend_next;
    logic                 pend_have_reg, pend_have_next;

    logic                 out_valid_reg, out_valid_next;
    val_t                 out_value_reg, out_value_next;
    logic                 out_last_reg, out_last_next;
    logic [OUT_CNT_W-1:0] out_count_reg, out_count_next;
    logic                 out_empty_reg, out_empty_next;
    logic                 out_ovf_reg, out_ovf_next;

    logic          in_acc, load_a, load_b, run;
    logic          out_free, step;
    logic          ins_a, ins_b, pop_a, pop_b, clr;
    val_t          head_a, head_b;
    logic [CW-1:0] cnt_a, cnt_b;
    logic          full_a, full_b;
    logic          a_has, b_has, active, emit, m_pop_a, m_pop_b;
    val_t          emit_val;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign load_a    = in_acc && (cmd == CMD_LOAD_A);
    assign load_b    = in_acc && (cmd == CMD_LOAD_B);
    assign run       = in_acc && (cmd == CMD_RUN);
    assign out_free  = !out_valid_reg || !out_stall;
    assign step      = (state_reg == ST_MERGE) && out_free;

    assign ins_a = load_a;
    assign ins_b = load_b;
    assign pop_a = step && active && m_pop_a;
    assign pop_b = step && active && m_pop_b;
    assign clr   = step && !active;

    sso_chain #(.DEPTH(LIST_DEPTH), .CW(CW)) u_chain_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .insert  (ins_a),
        .pop     (pop_a),
        .clear   (clr),
        .new_val (value),
        .head    (head_a),
        .count   (cnt_a),
        .full    (full_a)
    );

    sso_chain #(.DEPTH(LIST_DEPTH), .CW(CW)) u_chain_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .insert  (ins_b),
        .pop     (pop_b),
        .clear   (clr),
        .new_val (value),
        .head    (head_b),
        .count   (cnt_b),
        .full    (full_b)
    );

    assign a_has = (cnt_a != '0);
    assign b_has = (cnt_b != '0);

    // one merge decision per cycle on the two list heads, applied only when step is set
    always_comb
    begin
        active   = 1'b0;
        emit     = 1'b0;
        emit_val = head_a;
        m_pop_a  = 1'b0;
        m_pop_b  = 1'b0;
        case (mode_reg)
            MODE_UNION: active = a_has || b_has;
            MODE_INTER: active = a_has && b_has;
            MODE_DIFF:  active = a_has;
            default:    active = 1'b0;
        endcase
        if (a_has && b_has)
        begin
            if (head_a == head_b)
            begin
                m_pop_a = 1'b1;
                m_pop_b = 1'b1;
                emit    = (mode_reg != MODE_DIFF);
            end
            else if (head_a < head_b)
            begin
                m_pop_a = 1'b1;
                emit    = (mode_reg != MODE_INTER);
            end
            else
            begin
                m_pop_b  = 1'b1;
                emit     = (mode_reg == MODE_UNION);
                emit_val = head_b;
            end
        end
        else if (a_has)
        begin
            m_pop_a = 1'b1;
            emit    = 1'b1;
        end
        else if (b_has)
        begin
            m_pop_b  = 1'b1;
            emit     = 1'b1;
            emit_val = head_b;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ovf_next       = ovf_reg;
        k_next         = k_reg;
        pend_next      = pend_reg;
        pend_have_next = pend_have_reg;

        out_valid_next = out_valid_reg && out_stall;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_count_next = out_count_reg;
        out_empty_next = out_empty_reg;
        out_ovf_next   = out_ovf_reg;

        if ((load_a && full_a) || (load_b && full_b))
            ovf_next = 1'b1;
        if (run)
            state_next = ST_MERGE;

        if (step)
        begin
            if (active)
            begin
                if (emit)
                begin
                    k_next         = k_reg + OUT_CNT_W'(1);
                    pend_next      = emit_val;
                    pend_have_next = 1'b1;
                    if (pend_have_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = pend_reg;
                        out_last_next  = 1'b0;
                        out_count_next = '0;
                        out_empty_next = 1'b0;
                        out_ovf_next   = ovf_reg;
                    end
                end
            end
            else
            begin
                // closing beat: held element as last, or the empty marker
                out_valid_next = 1'b1;
                out_value_next = pend_have_reg ? pend_reg : '0;
                out_last_next  = 1'b1;
                out_count_next = pend_have_reg ? k_reg : '0;
                out_empty_next = !pend_have_reg;
                out_ovf_next   = ovf_reg;
                state_next     = ST_IDLE;
                ovf_next       = 1'b0;
                k_next         = '0;
                pend_have_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_UNION;
            ovf_reg       <= 1'b0;
            k_reg         <= '0;
            pend_have_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ovf_reg       <= ovf_next;
            k_reg         <= k_next;
            pend_have_reg <= pend_have_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                mode_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg      <= pend_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_count_reg <= out_count_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_value     = out_value_reg;
    assign out_last      = out_last_reg;
    assign out_count     = out_count_reg;
    assign out_empty     = out_empty_reg;
    assign load_overflow = out_ovf_reg;

endmodule

[hdl/sso_checker.sv]
`timescale 1ns / 1ps
// Port-level checks on the result stream of the sorted set operations unit.
// Depends on sso_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module sso_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [sso_pkg::VAL_W-1:0]     out_value,
    input logic                          out_last,
    input logic [sso_pkg::OUT_CNT_W-1:0] out_count,
    input logic                          out_empty
);
    import sso_pkg::*;

    // a stalled beat stays offered
    `ASSERT_CLK(a_stall_hold, out_valid && out_stall |=> out_valid && $stable(out_value), "stalled beat dropped or changed")
    // the empty marker is always the closing beat with a zero count
    `ASSERT_CLK(a_empty_last, out_valid && out_empty |-> out_last && (out_count == '0), "empty beat not closing")
    // count appears only on the closing beat
    `ASSERT_CLK(a_count_last, out_valid && !out_last |-> (out_count == '0) && !out_empty, "count or empty on inner beat")
    // a non-empty run closes with a nonzero count
    `ASSERT_CLK(a_count_nz, out_valid && out_last && !out_empty |-> (out_count != '0), "non-empty run closed with zero count")

endmodule

bind sorted_set_operations_unit sso_checker u_sso_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value),
    .out_last  (out_last),
    .out_count (out_count),
    .out_empty (out_empty)
);

[bench/sorted_set_operations_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for sorted_set_operations_unit: directed and random set runs.
// Depends on sso_pkg and the unit; keeps its own shadow lists to predict merge results.
module sorted_set_operations_unit_tb;

    import sso_pkg::*;

    localparam int LIST_DEPTH    = 32;
    localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PRINT_LIMIT   = 100;

    // codes outside the named package range
    localparam logic [CMD_W-1:0]  CMD_NOP   = 2'd3;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    localparam val_t VAL_MAX = {VAL_W{1'b1}};

    // value spreads for random loads
    localparam int SPREAD_NARROW = 0;
    localparam int SPREAD_FULL   = 1;
    localparam int SPREAD_EDGES  = 2;

    typedef struct packed {
        val_t                 value;
        logic                 last;
        logic [OUT_CNT_W-1:0] count;
        logic                 empty;
        logic                 ovf;
    } set_beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [CMD_W-1:0]     cmd = CMD_LOAD_A;
    val_t                 value = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    val_t                 out_value;
    logic                 out_last;
    logic [OUT_CNT_W-1:0] out_count;
    logic                 out_empty;
    logic                 load_overflow;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [MODE_W-1:0]    cfg_data = MODE_UNION;

    // shadow state of the unit
    val_t              shadow_a[$];
    val_t              shadow_b[$];
    logic              shadow_ovf = 1'b0;
    logic [MODE_W-1:0] shadow_mode = MODE_UNION;
    set_beat_t         set_results_due[$];

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int mismatches = 0;
    int items_sent = 0;
    int runs_sent = 0;
    int beats_seen = 0;

    sorted_set_operations_unit #(
        .LIST_DEPTH(LIST_DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_value    (out_value),
        .out_last     (out_last),
        .out_count    (out_count),
        .out_empty    (out_empty),
        .load_overflow(load_overflow),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    // Update the shadow lists for one accepted beat; a run queues its merged result.
    function automatic void apply_command(input logic [CMD_W-1:0] c, input val_t v);
        val_t      a[$];
        val_t      b[$];
        val_t      merged[$];
        set_beat_t r;
        int        ia;
        int        ib;
        ia = 0;
        ib = 0;
        case (c)
            CMD_LOAD_A:
                if (shadow_a.size() < LIST_DEPTH)
                    shadow_a.push_back(v);
                else
                    shadow_ovf = 1'b1;
            CMD_LOAD_B:
                if (shadow_b.size() < LIST_DEPTH)
                    shadow_b.push_back(v);
                else
                    shadow_ovf = 1'b1;
            CMD_RUN:
            begin
                runs_sent++;
                a = shadow_a;
                b = shadow_b;
                a.sort();
                b.sort();
                if (shadow_mode != MODE_NONE)
                begin
                    while (ia < a.size() && ib < b.size())
                    begin
                        // equal heads advance both lists
                        if (a[ia] == b[ib])
                        begin
                            if (shadow_mode != MODE_DIFF)
                                merged.push_back(a[ia]);
                            ia++;
                            ib++;
                        end
                        else if (a[ia] < b[ib])
                        begin
                            if (shadow_mode != MODE_INTER)
                                merged.push_back(a[ia]);
                            ia++;
                        end
                        else
                        begin
                            if (shadow_mode == MODE_UNION)
                                merged.push_back(b[ib]);
                            ib++;
                        end
                    end
                    if (shadow_mode != MODE_INTER)
                        while (ia < a.size())
                        begin
                            merged.push_back(a[ia]);
                            ia++;
                        end
                    if (shadow_mode == MODE_UNION)
                        while (ib < b.size())
                        begin
                            merged.push_back(b[ib]);
                            ib++;
                        end
                end
                r.ovf = shadow_ovf;
                if (merged.size() == 0)
                begin
                    r.value = '0;
                    r.last  = 1'b1;
                    r.count = '0;
                    r.empty = 1'b1;
                    set_results_due.push_back(r);
                end
                else
                    for (int i = 0; i < merged.size(); i++)
                    begin
                        r.value = merged[i];
                        r.last  = (i == merged.size() - 1);
                        r.count = r.last ? OUT_CNT_W'(merged.size()) : '0;
                        r.empty = 1'b0;
                        set_results_due.push_back(r);
                    end
                shadow_a.delete();
                shadow_b.delete();
                shadow_ovf = 1'b0;
            end
            default: ;
        endcase
    endfunction

    function automatic val_t pick_value(input int spread);
        logic [31:0] r;
        r = $urandom();
        case (spread)
            SPREAD_NARROW: pick_value = {{(VAL_W-4){1'b0}}, r[3:0]};
            SPREAD_EDGES:  pick_value = r[0] ? VAL_MAX - {{(VAL_W-3){1'b0}}, r[3:1]}
                                             : {{(VAL_W-3){1'b0}}, r[3:1]};
            default:       pick_value = r[VAL_W-1:0];
        endcase
    endfunction

    // mostly short lists of 0 to 8, now and then 20 to 34, up to and past full
    function automatic int pick_size();
        if ($urandom_range(11) == 0)
            pick_size = $urandom_range(34, 20);
        else
            pick_size = $urandom_range(8);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        // keep the log readable when the unit is badly off
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] result beat %0d: %s is 0x%0h, expected 0x%0h",
                     $time, beats_seen, what, got, want);
    endtask

    // One input beat; valid stays high on return so back-to-back beats need no gap.
    task automatic send_item(input logic [CMD_W-1:0] c, input val_t v);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_command(c, v);
        if (c != CMD_NOP)
            items_sent++;
    endtask

    // Sender pauses until every queued result beat has come back.
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (set_results_due.size() != 0);
    endtask

    task automatic set_mode_idle(input logic [MODE_W-1:0] m);
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_mode = m;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_set(input int na, input int nb, input int spread);
        int left_a;
        int left_b;
        left_a = na;
        left_b = nb;
        while (left_a + left_b > 0)
        begin
            if ($urandom_range(19) == 0)
                send_item(CMD_NOP, pick_value(SPREAD_FULL));
            if (left_b == 0 || (left_a > 0 && $urandom_range(1) == 0))
            begin
                send_item(CMD_LOAD_A, pick_value(spread));
                left_a--;
            end
            else
            begin
                send_item(CMD_LOAD_B, pick_value(spread));
                left_b--;
            end
        end
        send_item(CMD_RUN, pick_value(SPREAD_FULL));
    endtask

    // Empty run, ignored command, and a run that shows the ignored command left no trace.
    task automatic test_empty_and_noop();
        send_item(CMD_RUN, VAL_MAX);
        send_item(CMD_LOAD_A, 31'd9);
        send_item(CMD_NOP, VAL_MAX);
        send_item(CMD_RUN, '0);
    endtask

    task automatic test_union_extremes();
        send_item(CMD_LOAD_A, VAL_MAX);
        send_item(CMD_LOAD_A, '0);
        send_item(CMD_LOAD_B, 31'd5);
        send_item(CMD_LOAD_A, 31'd5);
        send_item(CMD_LOAD_B, 31'h2AAA_AAAA);
        send_item(CMD_LOAD_A, 31'd5);
        send_item(CMD_LOAD_B, VAL_MAX);
        send_item(CMD_LOAD_B, 31'h5555_5555);
        send_item(CMD_RUN, 31'h5555_5555);
    endtask

    task automatic test_intersection();
        set_mode_idle(MODE_INTER);
        send_item(CMD_LOAD_A, 31'd7);
        send_item(CMD_LOAD_A, 31'd3);
        send_item(CMD_LOAD_A, 31'd3);
        send_item(CMD_LOAD_B, 31'd3);
        send_item(CMD_LOAD_B, 31'd9);
        send_item(CMD_RUN, '0);
    endtask

    task automatic test_difference();
        set_mode_idle(MODE_DIFF);
        send_item(CMD_LOAD_A, 31'd2);
        send_item(CMD_LOAD_A, VAL_MAX);
        send_item(CMD_LOAD_B, 31'd2);
        send_item(CMD_LOAD_A, 31'd1);
        send_item(CMD_LOAD_A, 31'd2);
        send_item(CMD_RUN, '0);
        // everything in A also in B: empty result
        send_item(CMD_LOAD_A, 31'd4);
        send_item(CMD_LOAD_B, 31'd4);
        send_item(CMD_RUN, '0);
    endtask

    task automatic test_mode_none();
        set_mode_idle(MODE_NONE);
        send_item(CMD_LOAD_A, 31'd4);
        send_item(CMD_LOAD_B, 31'd4);
        send_item(CMD_RUN, '0);
    endtask

    // Both lists past full: dropped loads, sticky overflow, largest union; then flag cleared.
    task automatic test_full_lists();
        set_mode_idle(MODE_UNION);
        send_random_set(LIST_DEPTH + 2, LIST_DEPTH + 1, SPREAD_FULL);
        send_random_set(0, LIST_DEPTH + 1, SPREAD_NARROW);
        send_random_set(2, 1, SPREAD_EDGES);
    endtask

    // Receiver holds off while the sender keeps offering runs and loads.
    task automatic test_backpressure();
        wait_until_drained();
        idle_pct  = 0;
        stall_pct = 0;
        hold_requests <= hold_requests + 1;
        send_random_set(6, 6, SPREAD_NARROW);
        send_random_set(10, 4, SPREAD_FULL);
        send_random_set(3, 8, SPREAD_EDGES);
        wait_until_drained();
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct, input int n_items);
        int target;
        wait_until_drained();
        idle_pct  = send_pct;
        stall_pct = recv_pct;
        target    = items_sent + n_items;
        while (items_sent < target)
        begin
            case ($urandom_range(7))
                0: set_mode_idle(MODE_W'($urandom_range(3)));
                1: wait_until_drained();
                default: ;
            endcase
            send_random_set(pick_size(), pick_size(), $urandom_range(2));
        end
    endtask

    // Receiver: random stall, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_left == 0 && hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        set_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_seen++;
            if (set_results_due.size() == 0)
                report_mismatch("unexpected beat, out_value", out_value, 0);
            else
            begin
                want = set_results_due.pop_front();
                // out_value carries nothing on an empty-result beat
                if (!want.empty && out_value !== want.value)
                    report_mismatch("out_value", out_value, want.value);
                if (out_last !== want.last)
                    report_mismatch("out_last", out_last, want.last);
                if (out_count !== want.count)
                    report_mismatch("out_count", out_count, want.count);
                if (out_empty !== want.empty)
                    report_mismatch("out_empty", out_empty, want.empty);
                if (load_overflow !== want.ovf)
                    report_mismatch("load_overflow", load_overflow, want.ovf);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("sorted_set_operations_unit regression: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_noop();
        test_union_extremes();
        test_intersection();
        test_difference();
        test_mode_none();
        test_full_lists();
        test_backpressure();
        test_random_phase(0, 0, 40);
        test_random_phase(76, 0, 40);
        test_random_phase(0, 76, 40);
        test_random_phase(29, 29, 40);

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (set_results_due.size() != 0)
            report_mismatch("result beats still due", set_results_due.size(), 0);

        $display("covered %0d load/run beats in %0d runs, %0d result beats checked",
                 items_sent, runs_sent, beats_seen);
        $display("all four set modes, full lists, long receiver hold-off, four idle mixes");
        if (mismatches == 0)
            $display("sorted_set_operations_unit regression: pass");
        else
            $display("sorted_set_operations_unit regression: fail");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/sso_pkg.sv
hdl/sso_cell.sv
hdl/sso_chain.sv
hdl/sorted_set_operations_unit.sv
hdl/sso_checker.sv
bench/sorted_set_operations_unit_tb.sv
